>>> design/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Clocked assertion shorthands used by the cache checker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication
`define LKV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, defaults, command codes and the cell control bundle.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int LOOKUP_KEY_W = 16;
    localparam int VALUE_W      = 32;
    localparam int CAP_W        = 5;
    localparam int CAP_RESET    = 16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic exec;
        logic clear;
        logic put;
        logic full;
        logic hit;
    } lkv_ctrl_t;

endpackage

>>> design/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One recency slot: compares its key, passes hit and value down the chain,
// and takes its upper neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lkv_ctrl_t                  ctrl,
    input  logic [KEY_BITS-1:0]        key,
    input  logic [KEY_BITS-1:0]        prev_key,
    input  logic signed [VALUE_W-1:0]  prev_value,
    input  logic                       prev_valid,
    input  logic                       hit_in,
    input  logic signed [VALUE_W-1:0]  val_in,
    output logic                       hit_out,
    output logic signed [VALUE_W-1:0]  val_out,
    output logic [KEY_BITS-1:0]        key_q,
    output logic signed [VALUE_W-1:0]  value_q,
    output logic                       valid_q
);

    logic [KEY_BITS-1:0]       key_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      match;
    logic                      shift;

    assign match   = valid_reg && (key_reg == key);
    assign hit_out = hit_in || match;
    assign val_out = match ? value_reg : val_in;

    // on a hit shift the slots up to and including the match; on a put miss shift the row
    assign shift = ctrl.exec &&
                   (ctrl.hit ? !hit_in : (ctrl.put && (!ctrl.full || valid_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign valid_q = valid_reg;

endmodule

>>> design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key to value cache with least-recently-used replacement,
// built as a row of recency-ordered cells; slot 0 holds the most recent word.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | s_valid s_ready s_cmd s_lookup_key      | in
//            | s_store_value                           |
//   result   | m_valid m_ready m_found m_read_value    | out
//   config   | cfg_valid cfg_ready cfg_capacity        | in
//
// One word per cycle unless a get stalls on m_ready; a get's result is registered.
// The request register and the match ripple along the cell row set the pace.
// Reset and capacity writes clear all valid bits at once; no clearing pass.
// A get waits in the request register while an earlier result is not taken.
// A put gives no result word.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [LOOKUP_KEY_W-1:0]       s_lookup_key,
    input  logic signed [VALUE_W-1:0]     s_store_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic signed [VALUE_W-1:0]     m_read_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CAP_W-1:0]              cfg_capacity
);

    localparam int CNT_W         = $clog2(ENTRIES + 1);
    localparam int CAP_RESET_EFF = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;

    logic                      busy_reg;
    logic                      cmd_reg;
    logic [KEY_BITS-1:0]       key_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;
    logic [CNT_W-1:0]          cap_reg;
    logic [CNT_W-1:0]          cap_next;
    logic                      m_valid_reg;
    logic                      m_found_reg;
    logic signed [VALUE_W-1:0] m_value_reg;

    logic                      exec;
    logic                      cfg_wr;
    logic                      hit;
    logic signed [VALUE_W-1:0] new_value;
    lkv_ctrl_t                 ctrl;

    logic [KEY_BITS-1:0]       key_q   [ENTRIES];
    logic signed [VALUE_W-1:0] value_q [ENTRIES];
    logic                      valid_q [ENTRIES];
    logic                      hit_c   [ENTRIES+1];
    logic signed [VALUE_W-1:0] val_c   [ENTRIES+1];

    assign exec      = busy_reg && ((cmd_reg == CMD_PUT) || !m_valid_reg || m_ready);
    assign s_ready   = !busy_reg || exec;
    assign cfg_ready = !busy_reg;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign hit       = hit_c[ENTRIES];
    assign new_value = (cmd_reg == CMD_PUT) ? value_reg : val_c[ENTRIES];

    assign ctrl.exec  = exec;
    assign ctrl.clear = cfg_wr;
    assign ctrl.put   = (cmd_reg == CMD_PUT);
    assign ctrl.full  = (fill_reg >= cap_reg);
    assign ctrl.hit   = hit;

    assign hit_c[0] = 1'b0;
    assign val_c[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [KEY_BITS-1:0]       pk;
        logic signed [VALUE_W-1:0] pv;
        logic                      pvld;
        if (i == 0) begin : g_head
            assign pk   = key_reg;
            assign pv   = new_value;
            assign pvld = 1'b1;
        end else begin : g_body
            assign pk   = key_q[i-1];
            assign pv   = value_q[i-1];
            assign pvld = valid_q[i-1];
        end
        lkv_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .key        (key_reg),
            .prev_key   (pk),
            .prev_value (pv),
            .prev_valid (pvld),
            .hit_in     (hit_c[i]),
            .val_in     (val_c[i]),
            .hit_out    (hit_c[i+1]),
            .val_out    (val_c[i+1]),
            .key_q      (key_q[i]),
            .value_q    (value_q[i]),
            .valid_q    (valid_q[i])
        );
    end

    always_comb begin
        if (cfg_capacity == '0) begin
            cap_next = CNT_W'(1);
        end else if (int'(cfg_capacity) > ENTRIES) begin
            cap_next = CNT_W'(ENTRIES);
        end else begin
            cap_next = CNT_W'(cfg_capacity);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cfg_wr) begin
            fill_next = '0;
        end else if (exec && ctrl.put && !hit && !ctrl.full) begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
            cap_reg     <= CNT_W'(CAP_RESET_EFF);
        end else begin
            fill_reg <= fill_next;
            if (cfg_wr) begin
                cap_reg <= cap_next;
            end
            if (s_valid && s_ready) begin
                busy_reg <= 1'b1;
            end else if (exec) begin
                busy_reg <= 1'b0;
            end
            if (exec && (cmd_reg == CMD_GET)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            key_reg   <= KEY_BITS'(s_lookup_key);
            value_reg <= s_store_value;
        end
        if (exec && (cmd_reg == CMD_GET)) begin
            m_found_reg <= hit;
            m_value_reg <= val_c[ENTRIES];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_value_reg;

endmodule

>>> design/lkv_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level assertions on the result channel and put-then-get behavior.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lkv_checker
    import lkv_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_cmd,
    input logic [LOOKUP_KEY_W-1:0]   s_lookup_key,
    input logic signed [VALUE_W-1:0] s_store_value,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_found,
    input logic signed [VALUE_W-1:0] m_read_value
);

    `LKV_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result word dropped while stalled")
    `LKV_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_found) && $stable(m_read_value), "result word changed while stalled")
    `LKV_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_found, m_read_value == '0, "miss word carries nonzero value")
    `LKV_ASSERT_NEXT(a_put_get, aclk, aresetn, (s_valid && s_ready && (s_cmd == CMD_PUT) && !m_valid) ##1 (s_valid && s_ready && (s_cmd == CMD_GET) && !m_valid && (s_lookup_key == $past(s_lookup_key))), ##1 (m_valid && m_found && (m_read_value == $past(s_store_value, 3))), "get after put of same key missed")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_cmd         (s_cmd),
    .s_lookup_key  (s_lookup_key),
    .s_store_value (s_store_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_read_value  (m_read_value)
);
